>>> src/arp_pkg.sv
// package: types, codes and constants of the arp responder and cache
package arp_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;

    localparam logic [10:0] MIN_ARP_LEN = 11'd28;
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;
    localparam logic [1:0]  TX_REQUEST  = 2'd1;
    localparam logic [1:0]  TX_REPLY    = 2'd2;
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] CFG_LOCAL_MAC = 2'd0;
    localparam logic [1:0] CFG_LOCAL_IP  = 2'd1;

    typedef enum logic [1:0] {
        REQ_RX     = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_SEND   = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FRAME = 2'd1,
        ST_UNMATCHED = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type   req_type;
        logic [10:0] frame_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } t_arp_req;

    typedef struct packed {
        logic        accepted;
        logic        tx_valid;
        logic [1:0]  tx_opcode;
        logic [47:0] tx_dest_mac;
        logic [47:0] tx_target_mac;
        logic [31:0] tx_target_ip;
        logic        lookup_hit;
        logic        found_resolved;
        logic [47:0] found_mac;
        logic        release_pending;
        t_status     status;
    } t_arp_res;

    typedef struct packed {
        logic add;
        logic resolve;
    } t_arp_cache_cmd;

    typedef struct packed {
        logic        hit;
        logic        full;
        logic        resolved;
        logic [47:0] mac;
    } t_arp_cache_stat;

endpackage

>>> src/arp_cache.sv
// arp cache: associative table of ip to mac entries with lowest-index search
module arp_cache #(
    parameter int CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [31:0]              i_key,
    input  logic [47:0]              i_mac,
    input  arp_pkg::t_arp_cache_cmd  i_cmd,
    output arp_pkg::t_arp_cache_stat o_stat
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [CACHE_ENTRIES-1:0] r_resolved;
    logic [31:0]              r_ip  [CACHE_ENTRIES];
    logic [47:0]              r_mac [CACHE_ENTRIES];

    logic [CACHE_ENTRIES-1:0] match;
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         free_idx;
    logic                     full;
    logic [IDX_W-1:0]         wr_idx;
    logic                     add_en;
    logic                     resolve_en;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_ip[i] == i_key);
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign full       = &r_valid;
    assign wr_idx     = hit ? hit_idx : free_idx;
    assign add_en     = i_cmd.add && (hit || !full);
    assign resolve_en = i_cmd.resolve && hit;

    assign o_stat.hit      = hit;
    assign o_stat.full     = full;
    assign o_stat.resolved = hit && r_resolved[hit_idx];
    assign o_stat.mac      = hit ? r_mac[hit_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_resolved <= '0;
        end else if (add_en) begin
            r_valid[wr_idx]    <= 1'b1;
            r_resolved[wr_idx] <= 1'b0;
        end else if (resolve_en) begin
            r_resolved[hit_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_en) begin
            r_ip[wr_idx]  <= i_key;
            r_mac[wr_idx] <= '0;
        end else if (resolve_en) begin
            r_mac[hit_idx] <= i_mac;
        end
    end

endmodule

>>> src/arp_responder_and_cache.sv
// top level: arp responder with arp cache for one interface
//
// usage
// - command channel: an item is taken at a clock edge with i_start high and
//   o_busy low; o_busy stays low, so a new item may be issued every cycle
// - each item gives one result beat on o_result, marked by o_result_valid
//   for exactly one cycle: the item is held in the input register, and the
//   result register then raises the beat
// - throughput: one item per cycle; the input register, the parallel cache
//   compare and the result register form the only path, and the cache is
//   updated at the edge that captures the result, so the next item sees it
// - configuration: i_cfg_valid with o_cfg_ready (always high) writes
//   local_mac (index 0) or local_ip (index 1) from i_cfg_data; the user must
//   write only while no item is in flight; the block does not enforce it
// - reset clears the cache valid and resolved flags and both configuration
//   registers; no clearing pass is needed
// - the receiver cannot stall: a result beat not taken in its cycle is gone
module arp_responder_and_cache #(
    parameter int CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  arp_pkg::t_arp_req i_req,
    output logic              o_result_valid,
    output arp_pkg::t_arp_res o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [47:0]       i_cfg_data
);

    logic                     r_in_valid;
    arp_pkg::t_arp_req        r_in;
    logic                     r_res_valid;
    arp_pkg::t_arp_res        r_res;
    arp_pkg::t_arp_res        n_res;
    logic [47:0]              r_local_mac;
    logic [31:0]              r_local_ip;

    logic [31:0]              key;
    arp_pkg::t_arp_cache_cmd  cmd;
    arp_pkg::t_arp_cache_stat stat;
    logic                     bad_frame;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= '0;
            r_local_ip  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                arp_pkg::CFG_LOCAL_MAC: r_local_mac <= i_cfg_data;
                arp_pkg::CFG_LOCAL_IP:  r_local_ip  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_in_valid  <= i_start && !o_busy;
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_in <= i_req;
        end
        r_res <= n_res;
    end

    assign key = (r_in.req_type == arp_pkg::REQ_RX) ? r_in.sender_ip : r_in.target_ip;

    assign bad_frame = (r_in.frame_len < arp_pkg::MIN_ARP_LEN) ||
                       ((r_in.opcode != arp_pkg::OPC_REQUEST) &&
                        (r_in.opcode != arp_pkg::OPC_REPLY));

    always_comb begin
        n_res       = '0;
        cmd         = '0;
        case (r_in.req_type)
            arp_pkg::REQ_RX: begin
                if (bad_frame) begin
                    n_res.status = arp_pkg::ST_BAD_FRAME;
                end else if (r_in.opcode == arp_pkg::OPC_REQUEST) begin
                    if (r_in.target_ip == r_local_ip) begin
                        n_res.accepted      = 1'b1;
                        n_res.tx_valid      = 1'b1;
                        n_res.tx_opcode     = arp_pkg::TX_REPLY;
                        n_res.tx_dest_mac   = r_in.sender_mac;
                        n_res.tx_target_mac = r_in.sender_mac;
                        n_res.tx_target_ip  = r_in.sender_ip;
                    end
                end else begin
                    n_res.accepted = 1'b1;
                    if (stat.hit) begin
                        cmd.resolve           = r_in_valid;
                        n_res.release_pending = 1'b1;
                    end else begin
                        n_res.status = arp_pkg::ST_UNMATCHED;
                    end
                end
            end
            arp_pkg::REQ_ADD: begin
                if (stat.hit || !stat.full) begin
                    cmd.add        = r_in_valid;
                    n_res.accepted = 1'b1;
                end else begin
                    n_res.status = arp_pkg::ST_FULL;
                end
            end
            arp_pkg::REQ_SEND: begin
                n_res.accepted     = 1'b1;
                n_res.tx_valid     = 1'b1;
                n_res.tx_opcode    = arp_pkg::TX_REQUEST;
                n_res.tx_dest_mac  = arp_pkg::MAC_BCAST;
                n_res.tx_target_ip = r_in.target_ip;
            end
            arp_pkg::REQ_LOOKUP: begin
                n_res.accepted       = 1'b1;
                n_res.lookup_hit     = stat.hit;
                n_res.found_resolved = stat.resolved;
                n_res.found_mac      = stat.mac;
            end
            default: ;
        endcase
    end

    arp_cache #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_cache (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key),
        .i_mac   (r_in.sender_mac),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

>>> src/arp_checker.sv
// checker: port-level properties of the arp responder and cache, with bind
module arp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_result_valid,
    input arp_pkg::t_arp_res o_result
);

    a_beat_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_result_valid)
        else $error("no result beat for a taken item");

    a_no_spurious_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(i_start && !o_busy, 2))
        else $error("result beat without a taken item");

    a_tx_opcode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.tx_valid) |-> (o_result.tx_opcode == 2'd0))
        else $error("tx opcode set without a frame");

    a_error_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != arp_pkg::ST_OK)) |->
        (!o_result.tx_valid && !o_result.release_pending))
        else $error("frame or release with an error status");

    a_tx_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.tx_valid) |-> o_result.accepted)
        else $error("frame sent for an item not accepted");

endmodule

bind arp_responder_and_cache arp_checker u_arp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
